// ----- src/bct_pkg.sv -----
`timescale 1ns / 1ps

package bct_pkg;

	// Table geometry and coordinate format
	localparam int TABLE_DEPTH = 64;
	localparam int COORD_BITS  = 16;
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int SLOT_BITS   = 6;
	localparam int SLOT_LIMIT  = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	// edge arithmetic: position + displacement + size never wraps here
	localparam int EW          = COORD_BITS + 3;

	// Operation codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// Stored box, pos_x in the lowest bits
	typedef struct packed {
		logic [SIZE_BITS-1:0]  size_y;
		logic [SIZE_BITS-1:0]  size_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [COORD_BITS-1:0] pos_x;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	// Controller to datapath commands
	typedef struct packed {
		logic cap;        // capture a request
		logic do_update;  // write box at requested slot
		logic do_remove;  // clear valid mark of requested slot
		logic a_clr;      // start free-slot search
		logic a_next;     // advance free-slot search
		logic a_take;     // store box in current free slot
		logic a_full;     // no free slot found
		logic q_rd_slot;  // fetch moving box
		logic q_load;     // latch moved box, start table scan
		logic q_scan;     // one scan step
		logic out_load;   // hand result to the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       slot_ok;
		logic       slot_vld;
		logic       free_here;
		logic       idx_last;
		logic       scan_last;
		logic       out_free;
	} status_t;

	function automatic logic signed [EW-1:0] sext_pos(input logic [COORD_BITS-1:0] p);
		return {{(EW - COORD_BITS){p[COORD_BITS-1]}}, p};
	endfunction

	function automatic logic signed [EW-1:0] zext_size(input logic [SIZE_BITS-1:0] s);
		return {{(EW - SIZE_BITS){1'b0}}, s};
	endfunction

endpackage

// ----- src/bct_ram.sv -----
`timescale 1ns / 1ps

module bct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/bct_datapath.sv -----
`timescale 1ns / 1ps

module bct_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bct_pkg::cmd_t       cmd,
	output bct_pkg::status_t    sts,
	input  logic [1:0]          s_tuser,
	input  logic [71:0]         s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata
);

	localparam int AW = bct_pkg::AW;
	localparam int CW = bct_pkg::CW;
	localparam int EW = bct_pkg::EW;
	localparam int CB = bct_pkg::COORD_BITS;
	localparam int SB = bct_pkg::SIZE_BITS;

	// Request registers
	logic [1:0]                 op_q;
	logic [5:0]                 slot_q;
	bct_pkg::box_t              box_q;
	logic [AW-1:0]              slot_addr;

	// Table state and scan control
	logic [bct_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]              scan_q;
	logic [AW-1:0]              cmp_idx_s1;
	logic                       cmp_en_s1;

	// Moved box edges
	logic signed [EW-1:0]       mv_x0_q, mv_x1_q, mv_y0_q, mv_y1_q;

	// Result
	logic                       can_q, full_q;
	logic [5:0]                 given_q;
	logic                       m_tvalid_q;
	logic [7:0]                 m_tdata_q;

	// Memory ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [bct_pkg::BOX_W-1:0]  ram_rdata;
	bct_pkg::box_t              rd_box;

	logic signed [EW-1:0]       mv_x0_d, mv_y0_d;
	logic signed [EW-1:0]       bx0, bx1, by0, by1;
	logic                       touch, hit;

	assign slot_addr = AW'(slot_q);
	assign rd_box    = bct_pkg::box_t'(ram_rdata);

	// Capture request fields from the input bus
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q         <= s_tuser;
			slot_q       <= s_tdata[5:0];
			box_q.pos_x  <= s_tdata[6 +: CB];
			box_q.pos_y  <= s_tdata[22 +: CB];
			box_q.size_x <= s_tdata[38 +: SB];
			box_q.size_y <= s_tdata[53 +: SB];
		end
	end

	// Box memory: write on update or append, read slot then scan
	assign ram_we    = cmd.do_update | cmd.a_take;
	assign ram_waddr = cmd.do_update ? slot_addr : scan_q[AW-1:0];
	always_comb begin
		if (cmd.q_rd_slot) begin
			ram_raddr = slot_addr;
		end else if (cmd.q_load) begin
			ram_raddr = '0;
		end else begin
			ram_raddr = scan_q[AW-1:0];
		end
	end

	bct_ram #(
		.WIDTH(bct_pkg::BOX_W),
		.DEPTH(bct_pkg::TABLE_DEPTH)
	) u_box_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (box_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.a_take) begin
			valid_q[scan_q[AW-1:0]] <= 1'b1;
		end else if (cmd.do_remove) begin
			valid_q[slot_addr] <= 1'b0;
		end
	end

	// Shared slot counter for free search and table scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			cmp_en_s1  <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			if (cmd.a_clr) begin
				scan_q <= '0;
			end else if (cmd.a_next) begin
				scan_q <= scan_q + 1'b1;
			end else if (cmd.q_load) begin
				scan_q <= CW'(1);
			end else if (cmd.q_scan && scan_q < CW'(bct_pkg::TABLE_DEPTH)) begin
				scan_q <= scan_q + 1'b1;
			end

			if (cmd.q_load) begin
				cmp_en_s1  <= 1'b1;
				cmp_idx_s1 <= '0;
			end else if (cmd.q_scan) begin
				cmp_en_s1  <= scan_q < CW'(bct_pkg::TABLE_DEPTH);
				cmp_idx_s1 <= scan_q[AW-1:0];
			end else begin
				cmp_en_s1  <= 1'b0;
			end
		end
	end

	// Moved box: fetched position plus displacement
	assign mv_x0_d = bct_pkg::sext_pos(rd_box.pos_x) + bct_pkg::sext_pos(box_q.pos_x);
	assign mv_y0_d = bct_pkg::sext_pos(rd_box.pos_y) + bct_pkg::sext_pos(box_q.pos_y);

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			mv_x0_q <= mv_x0_d;
			mv_x1_q <= mv_x0_d + bct_pkg::zext_size(rd_box.size_x);
			mv_y0_q <= mv_y0_d;
			mv_y1_q <= mv_y0_d + bct_pkg::zext_size(rd_box.size_y);
		end
	end

	// Closed-interval overlap against the scanned entry
	assign bx0   = bct_pkg::sext_pos(rd_box.pos_x);
	assign bx1   = bx0 + bct_pkg::zext_size(rd_box.size_x);
	assign by0   = bct_pkg::sext_pos(rd_box.pos_y);
	assign by1   = by0 + bct_pkg::zext_size(rd_box.size_y);
	assign touch = (mv_x0_q <= bx1) && (bx0 <= mv_x1_q) &&
	               (mv_y0_q <= by1) && (by0 <= mv_y1_q);
	assign hit   = cmd.q_scan && cmp_en_s1 && valid_q[cmp_idx_s1] &&
	               (cmp_idx_s1 != slot_addr) && touch;

	// Result fields
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			can_q   <= 1'b0;
			full_q  <= 1'b0;
			given_q <= '0;
		end else begin
			if (cmd.a_take) begin
				given_q <= 6'(scan_q);
			end
			if (cmd.a_full) begin
				full_q <= 1'b1;
			end
			if (cmd.q_load) begin
				can_q <= 1'b1;
			end else if (hit) begin
				can_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {full_q, given_q, can_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Status to controller
	assign sts.op        = op_q;
	assign sts.slot_ok   = 32'(slot_q) < 32'(bct_pkg::SLOT_LIMIT);
	assign sts.slot_vld  = valid_q[slot_addr];
	assign sts.free_here = !valid_q[scan_q[AW-1:0]];
	assign sts.idx_last  = scan_q == CW'(bct_pkg::SLOT_LIMIT - 1);
	assign sts.scan_last = cmp_en_s1 && (cmp_idx_s1 == AW'(bct_pkg::TABLE_DEPTH - 1));
	assign sts.out_free  = !m_tvalid_q || m_tready;

endmodule

// ----- src/bct_ctrl.sv -----
`timescale 1ns / 1ps

module bct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bct_pkg::status_t sts,
	output bct_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_AFREE = 3'd2;
	localparam logic [2:0] ST_QLOAD = 3'd3;
	localparam logic [2:0] ST_QSCAN = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.op)
					bct_pkg::OP_APPEND: begin
						cmd.a_clr = 1'b1;
						state_d   = ST_AFREE;
					end
					bct_pkg::OP_UPDATE: begin
						cmd.do_update = sts.slot_ok;
						state_d       = ST_FIN;
					end
					bct_pkg::OP_REMOVE: begin
						cmd.do_remove = sts.slot_ok;
						state_d       = ST_FIN;
					end
					bct_pkg::OP_QUERY: begin
						if (sts.slot_ok && sts.slot_vld) begin
							cmd.q_rd_slot = 1'b1;
							state_d       = ST_QLOAD;
						end else begin
							state_d = ST_FIN;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			// one valid mark per cycle, lowest free slot wins
			ST_AFREE: begin
				if (sts.free_here) begin
					cmd.a_take = 1'b1;
					state_d    = ST_FIN;
				end else if (sts.idx_last) begin
					cmd.a_full = 1'b1;
					state_d    = ST_FIN;
				end else begin
					cmd.a_next = 1'b1;
				end
			end
			ST_QLOAD: begin
				cmd.q_load = 1'b1;
				state_d    = ST_QSCAN;
			end
			ST_QSCAN: begin
				cmd.q_scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/box_collision_table_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: op; s_tdata: slot, pos_x, pos_y, size_x, size_y
// m_        out  m_tvalid/m_tready  m_tdata: can_move, given_slot, table_full
//
// Update, remove and an invalid-slot query go via EXEC to FIN, which loads the result;
// append first scans the valid marks from slot 0 for the first free one; a query of a
// valid slot fetches the moving box and checks each entry in turn, as the box memory has
// one read port. The next request is accepted the cycle after the result is loaded.
// Reset clears all valid marks at once; box memory contents are not cleared.
// A result stalls the controller only while the previous one is still not taken.

module box_collision_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] op
	input  logic [71:0] s_tdata,   // slot[5:0], pos_x[21:6], pos_y[37:22],
	                               // size_x[52:38], size_y[67:53], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // can_move[0], given_slot[6:1], table_full[7]
);

	bct_pkg::cmd_t    cmd;
	bct_pkg::status_t sts;

	bct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bct_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
